// ----- hdl/mksr_pkg.sv -----
// Package for the Morse key symbol reader: configuration indexes, reader phase codes,
// pattern sizing, register reset values, press event and result kind codes. No dependencies.
`timescale 1ns / 1ps

package mksr_pkg;

  // Pattern sizing
  localparam int MaxSymbols = 6;
  localparam int PatW       = MaxSymbols;
  localparam int LenW       = $clog2(MaxSymbols + 1);

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgDebounceMax  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOnThreshold  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffThreshold = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHoldMin      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLetterGap    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMessageGap   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxLetters   = 3'd6;

  // Register reset values
  localparam logic [3:0] RstDebounceMax  = 4'd1;
  localparam logic [3:0] RstOnThreshold  = 4'd1;
  localparam logic [3:0] RstOffThreshold = 4'd0;
  localparam logic [7:0] RstHoldMin      = 8'd25;
  localparam logic [7:0] RstLetterGap    = 8'd40;
  localparam logic [9:0] RstMessageGap   = 10'd100;
  localparam logic [7:0] RstMaxLetters   = 8'd32;

  // Reader phases
  localparam logic [1:0] PhaseIdle     = 2'd0;
  localparam logic [1:0] PhaseRead     = 2'd1;
  localparam logic [1:0] PhaseConvert  = 2'd2;
  localparam logic [1:0] PhaseTransmit = 2'd3;

  // Press events
  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvDot  = 2'd1;
  localparam logic [1:0] EvDash = 2'd2;

  // Result kinds
  localparam logic KindLetter  = 1'b0;
  localparam logic KindMessage = 1'b1;

endpackage

// ----- hdl/morse_key_symbol_reader_top.sv -----
// Morse key symbol reader, top level: input register, tick update logic and result register.
// Depends on mksr_pkg.
`timescale 1ns / 1ps

// Usage
// - Input channel: one request per key tick (key_level_i, reader_enable_i) on in_valid_i,
//   taken when in_stall_o is low. The sample goes into an input register.
// - The tick is applied from the input register: debounce, hold timing, then the reader phase
//   update. A tick gives zero or one result; a result lands in the output register.
// - Output channel: out_valid_o with result_kind_o, symbol_bits_o, symbol_count_o and
//   letter_total_o; taken when out_stall_i is low.
// - Path: an accepted request waits in the input register; its result lands in the output
//   register when the tick is applied, which out_stall_i can hold back.
// - Throughput: one request per clock while out_stall_i does not hold the result register;
//   the tick update between the input register and the result register is combinational.
// - Stall: while a result waits under out_stall_i, the input register still takes one
//   request; in_stall_o rises only when that register is also full.
// - Reset (rst_ni low, asynchronous): all tick state clears, configuration returns to its
//   defaults, both registers empty.
// - Configuration: write cfg_we_i / cfg_index_i / cfg_data_i while idle; no read-back.
module morse_key_symbol_reader_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [mksr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mksr_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          key_level_i,
  input  logic                          reader_enable_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [5:0]                    symbol_bits_o,
  output logic [2:0]                    symbol_count_o,
  output logic [7:0]                    letter_total_o
);
  import mksr_pkg::*;

  // Configuration registers
  logic [3:0] debounce_max_q, on_thr_q, off_thr_q;
  logic [7:0] hold_min_q, letter_gap_q, max_letters_q;
  logic [9:0] message_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_max_q <= RstDebounceMax;
      on_thr_q       <= RstOnThreshold;
      off_thr_q      <= RstOffThreshold;
      hold_min_q     <= RstHoldMin;
      letter_gap_q   <= RstLetterGap;
      message_gap_q  <= RstMessageGap;
      max_letters_q  <= RstMaxLetters;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDebounceMax:  debounce_max_q <= cfg_data_i[3:0];
        CfgOnThreshold:  on_thr_q       <= cfg_data_i[3:0];
        CfgOffThreshold: off_thr_q      <= cfg_data_i[3:0];
        CfgHoldMin:      hold_min_q     <= cfg_data_i[7:0];
        CfgLetterGap:    letter_gap_q   <= cfg_data_i[7:0];
        CfgMessageGap:   message_gap_q  <= cfg_data_i[9:0];
        CfgMaxLetters:   max_letters_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: result register blocked when full and stalled
  logic out_valid_q;
  logic in_valid_q;
  logic out_blocked;
  logic tick_fire;

  assign out_blocked = out_valid_q & out_stall_i;
  assign in_stall_o  = in_valid_q & out_blocked;
  assign tick_fire   = in_valid_q & ~out_blocked;

  // Input register
  logic in_key_q, in_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_key_q <= key_level_i;
      in_en_q  <= reader_enable_i;
    end
  end

  // Tick state
  logic [3:0]      deb_q, deb_d;
  logic            key_q, key_d;
  logic            pend_q, pend_d;
  logic [7:0]      hold_q, hold_d;
  logic [1:0]      phase_q, phase_d;
  logic [9:0]      msg_tmr_q, msg_tmr_d;
  logic [7:0]      let_tmr_q, let_tmr_d;
  logic [PatW-1:0] pat_q, pat_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      letters_q, letters_d;

  logic [1:0]      press_ev;
  logic [9:0]      msg_inc;
  logic [7:0]      let_inc;
  logic            res_ok;
  logic            res_kind;
  logic [PatW-1:0] res_pat;
  logic [LenW-1:0] res_len;
  logic [7:0]      res_total;

  always_comb begin
    deb_d     = deb_q;
    key_d     = key_q;
    pend_d    = pend_q;
    hold_d    = hold_q;
    phase_d   = phase_q;
    msg_tmr_d = msg_tmr_q;
    let_tmr_d = let_tmr_q;
    pat_d     = pat_q;
    len_d     = len_q;
    letters_d = letters_q;
    press_ev  = EvNone;
    res_ok    = 1'b0;
    res_kind  = KindLetter;
    res_pat   = '0;
    res_len   = '0;
    res_total = letters_q;
    msg_inc   = (msg_tmr_q != 10'h3FF) ? msg_tmr_q + 10'd1 : msg_tmr_q;
    let_inc   = (let_tmr_q != 8'hFF) ? let_tmr_q + 8'd1 : let_tmr_q;

    // key sampling, every tick
    if (key_q && hold_q != 8'hFF) begin
      hold_d = hold_q + 8'd1;
    end
    if (in_key_q && deb_q < debounce_max_q) begin
      deb_d = deb_q + 4'd1;
    end else if (!in_key_q && deb_q != 4'd0) begin
      deb_d = deb_q - 4'd1;
    end
    if (deb_d >= on_thr_q) begin
      key_d = 1'b1;
    end else if (deb_d <= off_thr_q) begin
      key_d = 1'b0;
    end
    if (key_q && !key_d) begin
      pend_d   = 1'b0;
      press_ev = (hold_d > hold_min_q) ? EvDash : EvDot;
    end else if (!key_q && key_d) begin
      pend_d = 1'b1;
      hold_d = 8'd0;
    end

    // reader phase
    if (in_en_q) begin
      case (phase_q)
        PhaseIdle: begin
          if (pend_d) phase_d = PhaseRead;
        end
        PhaseRead: begin
          msg_tmr_d = msg_inc;
          let_tmr_d = let_inc;
          if (msg_inc >= message_gap_q || letters_q >= max_letters_q) begin
            msg_tmr_d = '0;
            phase_d   = PhaseTransmit;
          end else if (let_inc >= letter_gap_q || len_q >= LenW'(MaxSymbols)) begin
            let_tmr_d = '0;
            phase_d   = PhaseConvert;
          end else if (pend_d || press_ev != EvNone) begin
            msg_tmr_d = '0;
            let_tmr_d = '0;
            if (!pend_d && len_q < LenW'(MaxSymbols)) begin
              if (press_ev == EvDash) pat_d = pat_q | (PatW'(1) << len_q);
              len_d = len_q + LenW'(1);
            end
          end
        end
        PhaseConvert: begin
          if (len_q != '0 && letters_q != 8'hFF) letters_d = letters_q + 8'd1;
          res_ok    = 1'b1;
          res_kind  = KindLetter;
          res_pat   = pat_q;
          res_len   = len_q;
          res_total = letters_d;
          pat_d     = '0;
          len_d     = '0;
          phase_d   = PhaseRead;
        end
        default: begin
          res_ok    = 1'b1;
          res_kind  = KindMessage;
          res_total = letters_q;
          letters_d = '0;
          phase_d   = PhaseIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= '0;
      key_q     <= 1'b0;
      pend_q    <= 1'b0;
      hold_q    <= '0;
      phase_q   <= PhaseIdle;
      msg_tmr_q <= '0;
      let_tmr_q <= '0;
      pat_q     <= '0;
      len_q     <= '0;
      letters_q <= '0;
    end else if (tick_fire) begin
      deb_q     <= deb_d;
      key_q     <= key_d;
      pend_q    <= pend_d;
      hold_q    <= hold_d;
      phase_q   <= phase_d;
      msg_tmr_q <= msg_tmr_d;
      let_tmr_q <= let_tmr_d;
      pat_q     <= pat_d;
      len_q     <= len_d;
      letters_q <= letters_d;
    end
  end

  // Result register; pattern fields carry the low bits of the pattern and length
  logic [15:0] pat_ext;
  logic [7:0]  len_ext;
  logic        res_kind_q;
  logic [5:0]  res_bits_q;
  logic [2:0]  res_count_q;
  logic [7:0]  res_total_q;

  assign pat_ext = 16'(res_pat);
  assign len_ext = 8'(res_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_blocked) begin
      out_valid_q <= tick_fire & res_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire && res_ok) begin
      res_kind_q  <= res_kind;
      res_bits_q  <= pat_ext[5:0];
      res_count_q <= len_ext[2:0];
      res_total_q <= res_total;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = res_kind_q;
  assign symbol_bits_o  = res_bits_q;
  assign symbol_count_o = res_count_q;
  assign letter_total_o = res_total_q;

endmodule

// ----- tb/morse_key_symbol_reader_top_tb.sv -----
// Self-checking testbench for the Morse key symbol reader top level.
// Sends key ticks and register writes and predicts each letter and message-end result.
// Depends on mksr_pkg and morse_key_symbol_reader_top.
`timescale 1ns / 1ps

module morse_key_symbol_reader_top_tb;
  import mksr_pkg::*;

  // Index past the register list, must be ignored by the block
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 3'd7;
  // Cycles with no handshake on either channel before the run is declared hung
  localparam int StallLimit = 2000;
  // Cycles after the last expected result before the block counts as idle
  localparam int DrainCycles = 4;

  typedef struct packed {
    logic             kind;
    logic [PatW-1:0]  bits;
    logic [LenW-1:0]  count;
    logic [7:0]       total;
  } reader_result_t;

  // DUT connections, all inputs known from time zero
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i     = CfgDebounceMax;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               key_level_i     = 1'b0;
  logic               reader_enable_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic               result_kind_o;
  logic [5:0]         symbol_bits_o;
  logic [2:0]         symbol_count_o;
  logic [7:0]         letter_total_o;

  morse_key_symbol_reader_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .key_level_i     (key_level_i),
    .reader_enable_i (reader_enable_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .symbol_bits_o   (symbol_bits_o),
    .symbol_count_o  (symbol_count_o),
    .letter_total_o  (letter_total_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Mirror of the block: configuration and tick state
  // ---------------------------------------------------------------------------
  logic [3:0]  cfg_deb_max;
  logic [3:0]  cfg_on_thr;
  logic [3:0]  cfg_off_thr;
  logic [7:0]  cfg_hold_min;
  logic [7:0]  cfg_letter_gap;
  logic [9:0]  cfg_msg_gap;
  logic [7:0]  cfg_max_letters;

  logic [3:0]      deb_level;
  logic            key_down;
  logic            press_open;
  logic [1:0]      press_kind;
  logic [7:0]      hold_cnt;
  logic [1:0]      rd_phase;
  logic [9:0]      msg_timer;
  logic [7:0]      ltr_timer;
  logic [PatW-1:0] pat_bits;
  logic [LenW-1:0] pat_len;
  logic [7:0]      ltr_count;

  // Results the block still owes, oldest first
  reader_result_t reader_results_q[$];

  // Run bookkeeping
  int unsigned items_sent       = 0;
  int unsigned settings_applied = 0;
  int unsigned letters_checked  = 0;
  int unsigned messages_checked = 0;
  int unsigned error_count      = 0;
  int unsigned quiet_cycles     = 0;
  bit          sender_idle_on   = 1'b1;
  bit          recv_idle_on     = 1'b1;
  int unsigned stall_hold_cycles = 0;

  function automatic void reset_mirror();
    cfg_deb_max     = RstDebounceMax;
    cfg_on_thr      = RstOnThreshold;
    cfg_off_thr     = RstOffThreshold;
    cfg_hold_min    = RstHoldMin;
    cfg_letter_gap  = RstLetterGap;
    cfg_msg_gap     = RstMessageGap;
    cfg_max_letters = RstMaxLetters;
    deb_level  = '0;
    key_down   = 1'b0;
    press_open = 1'b0;
    press_kind = EvNone;
    hold_cnt   = '0;
    rd_phase   = PhaseIdle;
    msg_timer  = '0;
    ltr_timer  = '0;
    pat_bits   = '0;
    pat_len    = '0;
    ltr_count  = '0;
  endfunction

  // One key tick: debounce and hold timing always, then the reader if enabled.
  function automatic void advance_key_reader(bit key, bit en);
    logic was_down;
    reader_result_t res;
    was_down   = key_down;
    press_kind = EvNone;
    if (was_down && hold_cnt != 8'd255) hold_cnt = hold_cnt + 8'd1;
    if (key && deb_level < cfg_deb_max) deb_level = deb_level + 4'd1;
    else if (!key && deb_level != 4'd0) deb_level = deb_level - 4'd1;
    // on test wins when the thresholds overlap
    if (deb_level >= cfg_on_thr) key_down = 1'b1;
    else if (deb_level <= cfg_off_thr) key_down = 1'b0;
    if (was_down && !key_down) begin
      press_open = 1'b0;
      press_kind = (hold_cnt > cfg_hold_min) ? EvDash : EvDot;
    end else if (!was_down && key_down) begin
      press_open = 1'b1;
      hold_cnt   = '0;
    end
    if (!en) return;

    case (rd_phase)
      PhaseIdle: begin
        if (press_open) rd_phase = PhaseRead;
      end
      PhaseRead: begin
        if (msg_timer != 10'd1023) msg_timer = msg_timer + 10'd1;
        if (ltr_timer != 8'd255) ltr_timer = ltr_timer + 8'd1;
        if (msg_timer >= cfg_msg_gap || ltr_count >= cfg_max_letters) begin
          msg_timer = '0;
          rd_phase  = PhaseTransmit;
        end else if (ltr_timer >= cfg_letter_gap || pat_len >= MaxSymbols) begin
          ltr_timer = '0;
          rd_phase  = PhaseConvert;
        end else if (press_open || press_kind != EvNone) begin
          msg_timer = '0;
          ltr_timer = '0;
          if (!press_open && pat_len < MaxSymbols) begin
            if (press_kind == EvDash) pat_bits[pat_len] = 1'b1;
            pat_len = pat_len + 1'b1;
          end
        end
      end
      PhaseConvert: begin
        // empty patterns still report but do not count as letters
        if (pat_len != 0 && ltr_count != 8'd255) ltr_count = ltr_count + 8'd1;
        res.kind  = KindLetter;
        res.bits  = pat_bits;
        res.count = pat_len;
        res.total = ltr_count;
        reader_results_q.push_back(res);
        pat_bits = '0;
        pat_len  = '0;
        rd_phase = PhaseRead;
      end
      default: begin
        // message end keeps any pattern in progress
        res.kind  = KindMessage;
        res.bits  = '0;
        res.count = '0;
        res.total = ltr_count;
        reader_results_q.push_back(res);
        ltr_count = '0;
        rd_phase  = PhaseIdle;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_tick(bit key, bit en);
    int unsigned gap;
    if (sender_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    key_level_i     <= key;
    reader_enable_i <= en;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_key_reader(key, en);
    items_sent++;
  endtask

  task automatic send_run(bit key, bit en, int unsigned n);
    repeat (n) send_tick(key, en);
  endtask

  // Stop offering, wait for every owed result, then let in-flight ticks land.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reader_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Caller makes sure the block is idle first.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CfgDataW-1:0];
    @(posedge clk_i);
    case (idx)
      CfgDebounceMax:  cfg_deb_max     = value[3:0];
      CfgOnThreshold:  cfg_on_thr      = value[3:0];
      CfgOffThreshold: cfg_off_thr     = value[3:0];
      CfgHoldMin:      cfg_hold_min    = value[7:0];
      CfgLetterGap:    cfg_letter_gap  = value[7:0];
      CfgMessageGap:   cfg_msg_gap     = value[9:0];
      CfgMaxLetters:   cfg_max_letters = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_config(int unsigned deb, int unsigned on_thr, int unsigned off_thr,
                              int unsigned hold, int unsigned ltr_gap, int unsigned msg_gap,
                              int unsigned max_ltr);
    settle();
    write_reg(CfgDebounceMax, deb);
    write_reg(CfgOnThreshold, on_thr);
    write_reg(CfgOffThreshold, off_thr);
    write_reg(CfgHoldMin, hold);
    write_reg(CfgLetterGap, ltr_gap);
    write_reg(CfgMessageGap, msg_gap);
    write_reg(CfgMaxLetters, max_ltr);
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, plus a long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned burst;
    forever begin
      @(negedge clk_i);
      if (stall_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_hold_cycles - 1) @(negedge clk_i);
        stall_hold_cycles = 0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  reader_result_t got_result;
  reader_result_t want_result;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_result = {result_kind_o, symbol_bits_o, symbol_count_o, letter_total_o};
      if (reader_results_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result kind=%0d bits=%b count=%0d total=%0d", $realtime,
                   got_result.kind, got_result.bits, got_result.count, got_result.total);
      end else begin
        want_result = reader_results_q.pop_front();
        if (want_result.kind == KindMessage) messages_checked++;
        else letters_checked++;
        if (got_result.kind !== want_result.kind || got_result.bits !== want_result.bits ||
            got_result.count !== want_result.count ||
            got_result.total !== want_result.total) begin
          error_count++;
          if (error_count <= 10)
            $display({"%0t: mismatch expected kind=%0d bits=%b count=%0d total=%0d,",
                      " got kind=%0d bits=%b count=%0d total=%0d"},
                     $realtime, want_result.kind, want_result.bits, want_result.count,
                     want_result.total, got_result.kind, got_result.bits, got_result.count,
                     got_result.total);
        end
      end
    end
  end

  // Watchdog: too long without a handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("timeout: no handshake for %0d cycles, %0d results owed", StallLimit,
               reader_results_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values untouched: a dot, a dash and a letter gap.
  task automatic test_reset_defaults();
    send_run(1'b1, 1'b1, 3);
    send_run(1'b0, 1'b1, 4);
    send_run(1'b1, 1'b1, 30);
    send_run(1'b0, 1'b1, 45);
  endtask

  // Short directed sequence: sampling while disabled, dot, dash, empty letter,
  // message end on the gap.
  task automatic test_symbol_basics();
    apply_config(1, 1, 0, 2, 4, 9, 2);
    send_run(1'b1, 1'b0, 1);   // press seen while reader held
    send_run(1'b1, 1'b1, 1);
    send_run(1'b0, 1'b1, 1);   // dot
    send_run(1'b1, 1'b1, 4);
    send_run(1'b0, 1'b1, 5);   // dash, then letter gap
    send_run(1'b0, 1'b1, 5);   // empty letter, then message gap
    send_run(1'b1, 1'b1, 1);
    send_run(1'b0, 1'b0, 2);   // release with reader held: event lost
    send_run(1'b0, 1'b1, 3);
  endtask

  // Patterns that fill up before the gap, and enough letters to hit the limit.
  task automatic test_full_pattern_and_letter_limit();
    apply_config(1, 1, 0, 2, 10, 60, 3);
    repeat (2) begin
      for (int k = 0; k <= MaxSymbols; k++) begin
        send_run(1'b1, 1'b1, (k % 2) ? 4 : 1);
        send_run(1'b0, 1'b1, 1);
      end
      send_run(1'b0, 1'b1, 12);
    end
    send_run(1'b0, 1'b1, 5);
  endtask

  // Slow debounce, overlapping thresholds, and an accumulator left above a
  // lowered saturation value.
  task automatic test_threshold_overlap();
    apply_config(5, 2, 3, 2, 6, 14, 4);
    send_run(1'b1, 1'b1, 3);
    send_run(1'b0, 1'b1, 1);
    send_run(1'b1, 1'b1, 1);
    send_run(1'b0, 1'b1, 2);
    send_run(1'b1, 1'b1, 6);
    send_run(1'b0, 1'b1, 8);
    send_run(1'b1, 1'b1, 6);
    settle();
    write_reg(CfgDebounceMax, 2);
    send_run(1'b1, 1'b1, 3);
    send_run(1'b0, 1'b1, 17);
    apply_config(7, 4, 4, 3, 8, 20, 3);
    repeat (20) send_tick($urandom_range(0, 3) != 0, 1'b1);
    send_run(1'b0, 1'b1, 14);
  endtask

  // Data bits above each register's width, the unmapped index, and a zero
  // saturation value that keeps the key released.
  task automatic test_register_masking();
    settle();
    write_reg(CfgDebounceMax, 10'h3F2);
    write_reg(CfgOnThreshold, 10'h3F1);
    write_reg(CfgOffThreshold, 10'h3F0);
    write_reg(CfgHoldMin, 10'h303);
    write_reg(CfgLetterGap, 10'h305);
    write_reg(CfgMessageGap, 10'h3FF);
    write_reg(CfgMaxLetters, 10'h302);
    write_reg(CfgUnmapped, 10'h3FF);
    settings_applied++;
    repeat (20) send_tick($urandom_range(0, 1) != 0, 1'b1);
    settle();
    write_reg(CfgDebounceMax, 10'h3F0);
    repeat (10) send_tick(1'b1, 1'b1);
    send_run(1'b0, 1'b1, 5);
  endtask

  // Hold counter stops at its top: a press far past 255 ticks still counts one
  // above a limit of 254 and gives a dash.
  task automatic test_hold_saturation();
    apply_config(1, 1, 0, 254, 3, 20, 8);
    send_run(1'b1, 1'b1, 258);
    send_run(1'b0, 1'b1, 8);
  endtask

  // Receiver holds off for a long stretch while ticks keep coming, so the
  // result register and then the input register fill up.
  task automatic test_output_backpressure();
    apply_config(1, 1, 0, 1, 2, 6, 3);
    stall_hold_cycles = 60;
    repeat (70) send_tick($urandom_range(0, 1) != 0, 1'b1);
  endtask

  // Keying traffic: mostly well-formed letters, some noise and broken presses.
  task automatic morse_traffic(int unsigned n_items);
    int unsigned start_count, pick, n_sym, press_len, gap_len, gap_top, dot_top;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n_sym   = $urandom_range(1, MaxSymbols + 1);
        dot_top = (cfg_hold_min > 40) ? 40 : ((cfg_hold_min == 0) ? 1 : int'(cfg_hold_min));
        gap_top = (cfg_letter_gap > 21) ? 20 :
                  ((cfg_letter_gap > 2) ? int'(cfg_letter_gap) - 1 : 1);
        for (int k = 0; k < n_sym; k++) begin
          if (cfg_hold_min > 40 || $urandom_range(0, 1) == 0)
            press_len = $urandom_range(1, dot_top);
          else
            press_len = int'(cfg_hold_min) + $urandom_range(1, 3);
          send_run(1'b1, 1'b1, press_len + cfg_on_thr);
          send_run(1'b0, 1'b1, $urandom_range(1, gap_top) + cfg_deb_max);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) gap_len = int'(cfg_letter_gap) + $urandom_range(0, 3);
        else if (pick < 85) gap_len = int'(cfg_msg_gap) + $urandom_range(0, 3);
        else gap_len = $urandom_range(1, 3);
        send_run(1'b0, 1'b1, (gap_len > 300) ? 300 : gap_len);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8))
          send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      end else begin
        // glitchy press, part of it with the reader held
        send_run(1'b1, 1'b1, $urandom_range(1, 3));
        send_run(1'b0, 1'b1, 1);
        send_run(1'b1, 1'b0, $urandom_range(1, 3));
        send_run(1'b0, 1'b0, $urandom_range(1, 4));
      end
    end
  endtask

  task automatic pick_random_config();
    int unsigned deb, hold, ltr;
    deb  = $urandom_range(1, 4);
    hold = $urandom_range(1, 6);
    ltr  = $urandom_range(hold + 4, hold + 12);
    apply_config(deb, $urandom_range(1, deb), $urandom_range(0, 3), hold, ltr,
                 $urandom_range(2 * ltr, 3 * ltr), $urandom_range(1, 6));
  endtask

  // Random settings, and an on threshold of zero.
  task automatic test_random_traffic();
    for (int s = 0; s < 2; s++) begin
      case (s)
        1: begin
          // on threshold zero keeps the key pressed: message ends back to back
          apply_config(1, 0, 0, 1, 1, 1, 1);
          morse_traffic(30);
        end
        default: begin
          pick_random_config();
          morse_traffic(30);
        end
      endcase
    end
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_steady_stream();
    settle();
    sender_idle_on = 1'b0;
    recv_idle_on   = 1'b0;
    pick_random_config();
    morse_traffic(40);
  endtask

  initial begin
    reset_mirror();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_symbol_basics();
    test_full_pattern_and_letter_limit();
    test_threshold_overlap();
    test_register_masking();
    test_hold_saturation();
    test_output_backpressure();
    test_random_traffic();
    test_steady_stream();

    settle();
    repeat (6) @(posedge clk_i);
    $display("Sent %0d key ticks over %0d register settings, with a long output hold-off.",
             items_sent, settings_applied);
    $display("Checked %0d letter and %0d message-end results; %0d errors, %0d still owed.",
             letters_checked, messages_checked, error_count, reader_results_q.size());
    if (error_count == 0 && reader_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mksr_pkg.sv
hdl/morse_key_symbol_reader_top.sv
tb/morse_key_symbol_reader_top_tb.sv
